### hw/rtl/mpcd_pkg.sv
// ----------------------------------------------------------------------------
// mpcd_pkg
// shared types and constants of the mouse packet cursor decoder
// ----------------------------------------------------------------------------
package mpcd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned VAL_W      = 13;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned NUM_EVB    = 8;
  localparam int unsigned SEL_W      = $clog2(NUM_EVB);

  // bit 3 of the first byte is always set by the mouse
  localparam int unsigned SYNC_BIT = 3;

  typedef enum logic [1:0] {
    EV_REL  = 2'd0,
    EV_KEY  = 2'd1,
    EV_ABS  = 2'd2,
    EV_SYNC = 2'd3
  } ev_kind_e;

  localparam logic [1:0] CODE_X      = 2'd0;
  localparam logic [1:0] CODE_Y      = 2'd1;
  localparam logic [1:0] CODE_LEFT   = 2'd0;
  localparam logic [1:0] CODE_RIGHT  = 2'd1;
  localparam logic [1:0] CODE_MIDDLE = 2'd2;
  localparam logic [1:0] CODE_NONE   = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd768;

  // pending-event bit positions, lowest goes out first
  localparam logic [SEL_W-1:0] EVB_REL_X  = 3'd0;
  localparam logic [SEL_W-1:0] EVB_REL_Y  = 3'd1;
  localparam logic [SEL_W-1:0] EVB_KEY_L  = 3'd2;
  localparam logic [SEL_W-1:0] EVB_KEY_R  = 3'd3;
  localparam logic [SEL_W-1:0] EVB_KEY_M  = 3'd4;
  localparam logic [SEL_W-1:0] EVB_ABS_X  = 3'd5;
  localparam logic [SEL_W-1:0] EVB_ABS_Y  = 3'd6;
  localparam logic [SEL_W-1:0] EVB_SYNC   = 3'd7;

  // one decoded packet, handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
    logic [BTN_W-1:0]  btn_chg;
    logic [BTN_W-1:0]  btn_new;
    logic [VAL_W-1:0]  x_val;
    logic [VAL_W-1:0]  y_val;
    logic              x_chg;
    logic              y_chg;
    logic              moved;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

endpackage

### hw/rtl/mpcd_front.sv
// ----------------------------------------------------------------------------
// mpcd_front
// byte framing, configuration registers and cursor update per packet
// ----------------------------------------------------------------------------
module mpcd_front #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mpcd_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                              cfg_valid_i,
  input  logic [mpcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpcd_pkg::SIZE_W-1:0]       cfg_data_i,
  input  mpcd_pkg::fifo_stat_t              fifo_stat_i,
  output logic                              push_o,
  output mpcd_pkg::pkt_t                    pkt_o
);

  localparam int unsigned BW    = mpcd_pkg::BYTE_W;
  localparam int unsigned VW    = mpcd_pkg::VAL_W;
  localparam int unsigned SUM_W = POS_BITS + 2;
  localparam int unsigned MW    = (POS_BITS >= mpcd_pkg::SIZE_W) ? POS_BITS + 1
                                                                 : mpcd_pkg::SIZE_W;

  function automatic logic [MW-1:0] eff_size(input logic [mpcd_pkg::SIZE_W-1:0] s);
    logic [MW-1:0] se;
    logic [MW-1:0] lim;
    se  = MW'(s);
    lim = MW'(1) << POS_BITS;
    if (s == '0) begin
      return MW'(1);
    end else if (se > lim) begin
      return lim;
    end
    return se;
  endfunction

  function automatic logic [POS_BITS-1:0] axis_max(input logic [mpcd_pkg::SIZE_W-1:0] s);
    return POS_BITS'(eff_size(s) - MW'(1));
  endfunction

  function automatic logic [POS_BITS-1:0] axis_mid(input logic [mpcd_pkg::SIZE_W-1:0] s);
    return POS_BITS'(eff_size(s) >> 1);
  endfunction

  logic                          enabled_q, enabled_d;
  logic [mpcd_pkg::SIZE_W-1:0]   width_q, width_d;
  logic [mpcd_pkg::SIZE_W-1:0]   height_q, height_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic [BW-1:0]                 held0_q, held0_d;
  logic [BW-1:0]                 held1_q, held1_d;
  logic [POS_BITS-1:0]           cur_x_q, cur_x_d;
  logic [POS_BITS-1:0]           cur_y_q, cur_y_d;
  logic [mpcd_pkg::BTN_W-1:0]    btn_q, btn_d;

  logic                          accept;
  logic [SUM_W-1:0]              sum_x, sum_y;
  logic [POS_BITS-1:0]           max_x, max_y, new_x, new_y;
  logic [mpcd_pkg::BTN_W-1:0]    btn_new;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // clamp both axes to the screen
  always_comb begin
    max_x = axis_max(width_q);
    max_y = axis_max(height_q);
    sum_x = {2'b00, cur_x_q} + {{(SUM_W-BW){held1_q[BW-1]}}, held1_q};
    sum_y = {2'b00, cur_y_q} - {{(SUM_W-BW){data_byte_i[BW-1]}}, data_byte_i};
    if (sum_x[SUM_W-1]) begin
      new_x = '0;
    end else if (sum_x[SUM_W-2:0] > {1'b0, max_x}) begin
      new_x = max_x;
    end else begin
      new_x = sum_x[POS_BITS-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      new_y = '0;
    end else if (sum_y[SUM_W-2:0] > {1'b0, max_y}) begin
      new_y = max_y;
    end else begin
      new_y = sum_y[POS_BITS-1:0];
    end
    btn_new = held0_q[mpcd_pkg::BTN_W-1:0];
  end

  always_comb begin
    enabled_d = enabled_q;
    width_d   = width_q;
    height_d  = height_q;
    cnt_d     = cnt_q;
    held0_d   = held0_q;
    held1_d   = held1_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    btn_d     = btn_q;
    push_o    = 1'b0;

    if (accept && enabled_q) begin
      priority if (cnt_q == 2'd0) begin
        if (data_byte_i[mpcd_pkg::SYNC_BIT]) begin
          held0_d = data_byte_i;
          cnt_d   = 2'd1;
        end
      end else if (cnt_q == 2'd1) begin
        held1_d = data_byte_i;
        cnt_d   = 2'd2;
      end else begin
        cnt_d   = 2'd0;
        cur_x_d = new_x;
        cur_y_d = new_y;
        btn_d   = btn_new;
        push_o  = 1'b1;
      end
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpcd_pkg::REG_ENABLED: enabled_d = cfg_data_i[0];
        mpcd_pkg::REG_WIDTH: begin
          width_d = cfg_data_i;
          cur_x_d = axis_mid(cfg_data_i);
        end
        mpcd_pkg::REG_HEIGHT: begin
          height_d = cfg_data_i;
          cur_y_d  = axis_mid(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pkt_o.dx      = held1_q;
    pkt_o.dy      = data_byte_i;
    pkt_o.btn_new = btn_new;
    pkt_o.btn_chg = btn_new ^ btn_q;
    pkt_o.x_val   = VW'(new_x);
    pkt_o.y_val   = VW'(new_y);
    pkt_o.x_chg   = (new_x != cur_x_q);
    pkt_o.y_chg   = (new_y != cur_y_q);
    pkt_o.moved   = (new_x != cur_x_q) || (new_y != cur_y_q) || (btn_new != btn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      width_q   <= mpcd_pkg::RESET_WIDTH;
      height_q  <= mpcd_pkg::RESET_HEIGHT;
      cnt_q     <= 2'd0;
      cur_x_q   <= axis_mid(mpcd_pkg::RESET_WIDTH);
      cur_y_q   <= axis_mid(mpcd_pkg::RESET_HEIGHT);
      btn_q     <= '0;
    end else begin
      enabled_q <= enabled_d;
      width_q   <= width_d;
      height_q  <= height_d;
      cnt_q     <= cnt_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      btn_q     <= btn_d;
    end
  end

  // held bytes are always written before use within a packet
  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

endmodule

### hw/rtl/mpcd_fifo.sv
// ----------------------------------------------------------------------------
// mpcd_fifo
// short packet queue between front and back
// ----------------------------------------------------------------------------
module mpcd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mpcd_pkg::pkt_t       pkt_i,
  input  logic                 pop_i,
  output mpcd_pkg::pkt_t       pkt_o,
  output mpcd_pkg::fifo_stat_t stat_o
);

  localparam int unsigned DEPTH = mpcd_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mpcd_pkg::pkt_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full      = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);
  assign pkt_o            = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

endmodule

### hw/rtl/mpcd_back.sv
// ----------------------------------------------------------------------------
// mpcd_back
// expands one packet into its event run, one event per cycle when not stalled
// ----------------------------------------------------------------------------
module mpcd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pkt_valid_i,
  input  mpcd_pkg::pkt_t                  pkt_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      event_kind_o,
  output logic [1:0]                      event_code_o,
  output logic signed [mpcd_pkg::VAL_W-1:0] event_value_o,
  output logic                            cursor_moved_o,
  output logic                            last_event_o
);

  localparam int unsigned VW = mpcd_pkg::VAL_W;
  localparam int unsigned BW = mpcd_pkg::BYTE_W;
  localparam int unsigned NE = mpcd_pkg::NUM_EVB;

  mpcd_pkg::pkt_t               rec_q;
  logic [NE-1:0]                mask_q, mask_d;
  logic                         vld_q, vld_d;
  mpcd_pkg::ev_kind_e           kind_q, kind_d;
  logic [1:0]                   code_q, code_d;
  logic [VW-1:0]                val_q, val_d;
  logic                         moved_q, moved_d;
  logic                         last_q, last_d;

  logic                         slot_free;
  logic [mpcd_pkg::SEL_W-1:0]   sel;
  logic [VW-1:0]                dx_ext, dy_ext;

  assign slot_free = !vld_q || out_ready_i;
  assign pop_o     = (mask_q == '0) && pkt_valid_i;
  assign dx_ext    = {{(VW-BW){rec_q.dx[BW-1]}}, rec_q.dx};
  assign dy_ext    = {{(VW-BW){rec_q.dy[BW-1]}}, rec_q.dy};

  // lowest pending bit goes first
  always_comb begin
    sel = '0;
    for (int i = NE - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = mpcd_pkg::SEL_W'(i);
      end
    end
  end

  always_comb begin
    kind_d  = mpcd_pkg::EV_SYNC;
    code_d  = mpcd_pkg::CODE_NONE;
    val_d   = '0;
    moved_d = 1'b0;
    last_d  = 1'b0;
    unique case (sel)
      mpcd_pkg::EVB_REL_X: begin
        kind_d = mpcd_pkg::EV_REL;
        code_d = mpcd_pkg::CODE_X;
        val_d  = dx_ext;
      end
      mpcd_pkg::EVB_REL_Y: begin
        kind_d = mpcd_pkg::EV_REL;
        code_d = mpcd_pkg::CODE_Y;
        val_d  = VW'(0) - dy_ext;
      end
      mpcd_pkg::EVB_KEY_L: begin
        kind_d = mpcd_pkg::EV_KEY;
        code_d = mpcd_pkg::CODE_LEFT;
        val_d  = {{(VW-1){1'b0}}, rec_q.btn_new[0]};
      end
      mpcd_pkg::EVB_KEY_R: begin
        kind_d = mpcd_pkg::EV_KEY;
        code_d = mpcd_pkg::CODE_RIGHT;
        val_d  = {{(VW-1){1'b0}}, rec_q.btn_new[1]};
      end
      mpcd_pkg::EVB_KEY_M: begin
        kind_d = mpcd_pkg::EV_KEY;
        code_d = mpcd_pkg::CODE_MIDDLE;
        val_d  = {{(VW-1){1'b0}}, rec_q.btn_new[2]};
      end
      mpcd_pkg::EVB_ABS_X: begin
        kind_d = mpcd_pkg::EV_ABS;
        code_d = mpcd_pkg::CODE_X;
        val_d  = rec_q.x_val;
      end
      mpcd_pkg::EVB_ABS_Y: begin
        kind_d = mpcd_pkg::EV_ABS;
        code_d = mpcd_pkg::CODE_Y;
        val_d  = rec_q.y_val;
      end
      default: begin
        moved_d = rec_q.moved;
        last_d  = 1'b1;
      end
    endcase
  end

  always_comb begin
    mask_d = mask_q;
    vld_d  = vld_q;
    if (slot_free) begin
      vld_d = (mask_q != '0);
      if (mask_q != '0) begin
        mask_d = mask_q & ~(NE'(1) << sel);
      end
    end
    if (pop_o) begin
      mask_d = {1'b1, pkt_i.y_chg, pkt_i.x_chg, pkt_i.btn_chg,
                (pkt_i.dy != '0), (pkt_i.dx != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= pkt_i;
    end
    if (slot_free && (mask_q != '0)) begin
      kind_q  <= kind_d;
      code_q  <= code_d;
      val_q   <= val_d;
      moved_q <= moved_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = vld_q;
  assign event_kind_o   = kind_q;
  assign event_code_o   = code_q;
  assign event_value_o  = val_q;
  assign cursor_moved_o = moved_q;
  assign last_event_o   = last_q;

endmodule

### hw/rtl/mouse_packet_cursor_decoder_unit.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_decoder_unit
// three-byte mouse packet decoder with clamped cursor and event runs
// ----------------------------------------------------------------------------
// Raw mouse bytes come in on the input channel, one per request. Once the
// enabled register is set, a byte with bit 3 set starts a packet; three bytes
// make one, and the cursor is moved by +dx / -dy and clamped to the screen
// size programmed in the width and height registers (writing one re-centers
// that axis). Each packet gives a run of one to eight events: rel x, rel y,
// changed buttons, abs x, abs y and a closing sync with last_event set.
// The front accepts one byte per cycle and only stalls its input when the
// two-entry queue is full; it does the cursor update on the third byte. The
// back sends one event per cycle while the receiver is ready and takes the
// next packet from the queue only once the current run is issued, so it never
// starts a packet before it is done with the last one. Configuration writes
// are taken in every cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_decoder_unit #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte request
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mpcd_pkg::BYTE_W-1:0]       data_byte_i,
  // register write request
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mpcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpcd_pkg::SIZE_W-1:0]       cfg_data_i,
  // event request
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        event_kind_o,
  output logic [1:0]                        event_code_o,
  output logic signed [mpcd_pkg::VAL_W-1:0] event_value_o,
  output logic                              cursor_moved_o,
  output logic                              last_event_o
);

  logic                 push;
  logic                 pop;
  mpcd_pkg::pkt_t       pkt_in;
  mpcd_pkg::pkt_t       pkt_out;
  mpcd_pkg::fifo_stat_t fifo_stat;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;

  // framing, registers and cursor state
  mpcd_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .pkt_o       (pkt_in)
  );

  // decoded packets wait here while the back drains a run
  mpcd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pkt_i  (pkt_in),
    .pop_i  (pop),
    .pkt_o  (pkt_out),
    .stat_o (fifo_stat)
  );

  // event sequencer with output register
  mpcd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pkt_valid_i    (fifo_stat.not_empty),
    .pkt_i          (pkt_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_code_o   (event_code_o),
    .event_value_o  (event_value_o),
    .cursor_moved_o (cursor_moved_o),
    .last_event_o   (last_event_o)
  );

endmodule

### hw/rtl/mpcd_checker.sv
// ----------------------------------------------------------------------------
// mpcd_checker
// port-level checks of the decoder's event channel
// ----------------------------------------------------------------------------
module mpcd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [1:0]                        event_kind_i,
  input logic signed [mpcd_pkg::VAL_W-1:0] event_value_i,
  input logic                              cursor_moved_i,
  input logic                              last_event_i
);

  // a stalled event stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("event dropped while stalled");

  // only the sync event closes a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_event_i |-> event_kind_i == mpcd_pkg::EV_SYNC)
    else $error("run closed by a non-sync event");

  // non-sync events carry no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i != mpcd_pkg::EV_SYNC |-> !last_event_i && !cursor_moved_i)
    else $error("flag set on a non-sync event");

  // button events report a level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == mpcd_pkg::EV_KEY |->
      event_value_i == '0 || event_value_i == mpcd_pkg::VAL_W'(1))
    else $error("button level out of range");

endmodule

bind mouse_packet_cursor_decoder_unit mpcd_checker u_mpcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_kind_i   (event_kind_o),
  .event_value_i  (event_value_o),
  .cursor_moved_i (cursor_moved_o),
  .last_event_i   (last_event_o)
);

### tb/sv/mouse_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_event_checker
// predicts and checks the event runs of the mouse packet decoder
// ----------------------------------------------------------------------------
// Watches the byte, register and event requests. Every accepted byte is
// run through an untimed model of the decoder, and the events it yields are
// queued. Every accepted event is compared field by field with the oldest
// queued one.
// ----------------------------------------------------------------------------
module mouse_event_checker #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [mpcd_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [mpcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpcd_pkg::SIZE_W-1:0]       cfg_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [1:0]                        event_kind_i,
  input  logic [1:0]                        event_code_i,
  input  logic signed [mpcd_pkg::VAL_W-1:0] event_value_i,
  input  logic                              cursor_moved_i,
  input  logic                              last_event_i,
  output int unsigned                       pending_o,
  output int unsigned                       mismatches_o
);

  import mpcd_pkg::*;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       code;
    logic [VAL_W-1:0] value;
    logic             moved;
    logic             last;
  } mouse_event_t;

  // decoder model state
  logic              en_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  int unsigned       count_q;
  logic [BYTE_W-1:0] held_q [2];
  int                cur_x;
  int                cur_y;
  logic [BTN_W-1:0]  btn_q;

  mouse_event_t predicted_events [$];
  mouse_event_t oldest;
  int unsigned  mismatches = 0;

  assign mismatches_o = mismatches;

  // zero acts as one, anything past the position range is cut down to it
  function automatic int usable_size(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > (1 << POS_BITS)) return 1 << POS_BITS;
    return int'(s);
  endfunction

  function automatic int clamp_axis(int v, logic [SIZE_W-1:0] s);
    int maxv;
    maxv = usable_size(s) - 1;
    if (v < 0) return 0;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void queue_event(logic [1:0] kind, logic [1:0] code, int value,
                                      logic moved, logic last);
    mouse_event_t ev;
    ev.kind  = kind;
    ev.code  = code;
    ev.value = value[VAL_W-1:0];
    ev.moved = moved;
    ev.last  = last;
    predicted_events.push_back(ev);
  endfunction

  function automatic void decode_mouse_byte(logic [BYTE_W-1:0] b);
    int               dx;
    int               dy;
    int               nx;
    int               ny;
    logic [BTN_W-1:0] btn_new;
    logic [BTN_W-1:0] changed;
    logic             moved;
    if (!en_q) return;
    // resync: a packet only starts on a byte with the sync bit
    if (count_q == 0 && !b[SYNC_BIT]) return;
    if (count_q < 2) begin
      held_q[count_q] = b;
      count_q++;
      return;
    end
    count_q = 0;
    dx      = $signed(held_q[1]);
    dy      = $signed(b);
    btn_new = held_q[0][BTN_W-1:0];
    changed = btn_new ^ btn_q;
    nx      = clamp_axis(cur_x + dx, width_q);
    ny      = clamp_axis(cur_y - dy, height_q);
    moved   = (nx != cur_x) || (ny != cur_y) || (changed != '0);
    if (dx != 0) queue_event(EV_REL, CODE_X, dx, 1'b0, 1'b0);
    if (dy != 0) queue_event(EV_REL, CODE_Y, -dy, 1'b0, 1'b0);
    if (changed[0]) queue_event(EV_KEY, CODE_LEFT, int'(btn_new[0]), 1'b0, 1'b0);
    if (changed[1]) queue_event(EV_KEY, CODE_RIGHT, int'(btn_new[1]), 1'b0, 1'b0);
    if (changed[2]) queue_event(EV_KEY, CODE_MIDDLE, int'(btn_new[2]), 1'b0, 1'b0);
    if (nx != cur_x) queue_event(EV_ABS, CODE_X, nx, 1'b0, 1'b0);
    if (ny != cur_y) queue_event(EV_ABS, CODE_Y, ny, 1'b0, 1'b0);
    queue_event(EV_SYNC, CODE_NONE, 0, moved, 1'b1);
    cur_x = nx;
    cur_y = ny;
    btn_q = btn_new;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      = 1'b0;
      width_q   = RESET_WIDTH;
      height_q  = RESET_HEIGHT;
      count_q   = 0;
      held_q[0] = '0;
      held_q[1] = '0;
      cur_x     = usable_size(RESET_WIDTH) / 2;
      cur_y     = usable_size(RESET_HEIGHT) / 2;
      btn_q     = '0;
      predicted_events.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLED: en_q = cfg_data_i[0];
          REG_WIDTH: begin
            width_q = cfg_data_i;
            cur_x   = usable_size(width_q) / 2;
          end
          REG_HEIGHT: begin
            height_q = cfg_data_i;
            cur_y    = usable_size(height_q) / 2;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_mouse_byte(data_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (predicted_events.size() == 0) begin
          $error("unexpected event: kind %0d code %0d value %0d",
                 event_kind_i, event_code_i, event_value_i);
          mismatches++;
        end else begin
          oldest = predicted_events.pop_front();
          check_field("event_kind", oldest.kind, event_kind_i);
          check_field("event_code", oldest.code, event_code_i);
          check_field("event_value", $signed(oldest.value), event_value_i);
          check_field("cursor_moved", oldest.moved, cursor_moved_i);
          check_field("last_event", oldest.last, last_event_i);
        end
      end
      pending_o <= predicted_events.size();
    end
  end

endmodule

### tb/sv/mouse_packet_cursor_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_packet_cursor_decoder_unit_tb
// stimulus and verdict for the mouse packet cursor decoder
// ----------------------------------------------------------------------------
// Drives raw mouse bytes and register writes into the decoder, while a
// checker beside it predicts every event run and compares it. A short
// directed part covers sync loss, extreme deltas, all buttons, disabling
// in the middle of a packet and odd screen sizes; then random phases with
// well-formed packets mixed with noise run under different screen sizes
// and idling patterns, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_decoder_unit_tb;

  import mpcd_pkg::*;

  localparam int unsigned POS_BITS      = 12;
  // margin after the last predicted event, so the pipeline runs empty
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned PHASE_BYTES   = 33;
  localparam int unsigned NOISE_PCT     = 12;

  // the decoder ignores this index
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // which registers a configuration step writes, one bit per index
  localparam logic [3:0] SET_ENABLE = 4'b0001;
  localparam logic [3:0] SET_HEIGHT = 4'b0100;
  localparam logic [3:0] SET_SIZE   = 4'b0110;
  localparam logic [3:0] SET_ALL    = 4'b0111;
  localparam logic [3:0] SET_EVERY  = 4'b1111;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [BYTE_W-1:0]          data_byte_i = '0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [SIZE_W-1:0]          cfg_data_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [1:0]                 event_kind_o;
  logic [1:0]                 event_code_o;
  logic signed [VAL_W-1:0]    event_value_o;
  logic                       cursor_moved_o;
  logic                       last_event_o;

  int unsigned pending;
  int unsigned mismatches;

  // idling knobs, percent of cycles
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold      = 1'b0;
  int unsigned quiet_cycles = 0;

  mouse_packet_cursor_decoder_unit #(
    .POS_BITS(POS_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .cursor_moved_o(cursor_moved_o),
    .last_event_o  (last_event_o)
  );

  mouse_event_checker #(
    .POS_BITS(POS_BITS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_i  (event_kind_o),
    .event_code_i  (event_code_o),
    .event_value_i (event_value_o),
    .cursor_moved_i(cursor_moved_o),
    .last_event_i  (last_event_o),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // event receiver: random stalls, or a full hold-off while rx_hold is set
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: too many cycles in a row with no request taken on any channel
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one byte request; valid stays up from one byte to the next unless the
  // sender decides to idle first
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] head, dx, dy);
    send_byte(head);
    send_byte(dx);
    send_byte(dy);
  endtask

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // wait for every predicted event, then let the pipeline run empty
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register writes only ever happen on an idle block
  task automatic configure(input logic [3:0] which, input logic en,
                           input logic [SIZE_W-1:0] w, h);
    drain();
    if (which[REG_ENABLED]) write_reg(REG_ENABLED, SIZE_W'(en));
    if (which[REG_WIDTH])   write_reg(REG_WIDTH, w);
    if (which[REG_HEIGHT])  write_reg(REG_HEIGHT, h);
    if (which[REG_UNUSED])  write_reg(REG_UNUSED, SIZE_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // zero often, so runs with and without motion events both show up
  function automatic logic [BYTE_W-1:0] motion_byte();
    if ($urandom_range(3) == 0) return '0;
    return BYTE_W'($urandom);
  endfunction

  // mostly well-formed packets, some stray bytes that break the framing
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        send_byte(BYTE_W'($urandom));
        sent++;
      end else begin
        send_packet({4'($urandom), 1'b1, 3'($urandom)}, motion_byte(), motion_byte());
        sent += 3;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // still disabled out of reset, these bytes must vanish
    send_byte(8'h08);
    send_byte(8'h7f);
    configure(SET_EVERY, 1'b1, RESET_WIDTH, RESET_HEIGHT);

    // a head without the sync bit is dropped
    send_byte(8'h00);
    // left button, largest right move, largest downward move
    send_packet(8'h09, 8'h7f, 8'h80);
    // every head bit set, overflow and sign bits ignored, extreme deltas
    send_packet(8'hff, 8'h80, 8'h7f);
    // all buttons released, no motion
    send_packet(8'h08, 8'h00, 8'h00);
    // right and middle, one step each way
    send_packet(8'h0e, 8'h01, 8'hff);

    // disabling mid packet keeps the byte position
    send_byte(8'h0c);
    send_byte(8'h05);
    configure(SET_ENABLE, 1'b0, '0, '0);
    send_byte(8'h33);
    configure(SET_ENABLE, 1'b1, '0, '0);
    send_byte(8'hfb);

    // one pixel screen, every move clamps to zero
    configure(SET_SIZE, 1'b1, 13'd1, 13'd1);
    send_packet(8'h08, 8'h7f, 8'h80);
    // zero width acts as one, oversized height is cut to the position range
    configure(SET_SIZE, 1'b1, 13'd0, 13'd8191);
    send_packet(8'h08, 8'h80, 8'h7f);

    // largest screen, no idling, long receiver hold-off fills the queue
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    configure(SET_SIZE, 1'b1, 13'd4096, 13'd4096);
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    random_traffic(PHASE_BYTES);

    // tiny screen, sender mostly idle
    tx_idle_pct  = 78;
    rx_stall_pct = 0;
    configure(SET_SIZE, 1'b1, 13'd8, 13'd5);
    random_traffic(PHASE_BYTES);

    // just past the range and zero, receiver mostly stalled
    tx_idle_pct  = 0;
    rx_stall_pct = 78;
    configure(SET_SIZE, 1'b1, 13'd4097, 13'd0);
    random_traffic(PHASE_BYTES);

    // height only, x keeps wherever it ended up
    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    configure(SET_HEIGHT, 1'b1, '0, 13'd1);
    random_traffic(PHASE_BYTES);

    // disabled stretch, then all registers at once
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    configure(SET_ENABLE, 1'b0, '0, '0);
    random_traffic(9);
    configure(SET_ALL, 1'b1, 13'd8191, 13'd1);
    random_traffic(PHASE_BYTES);

    // ordinary screen, no idling
    configure(SET_SIZE, 1'b1, 13'd640, 13'd480);
    random_traffic(PHASE_BYTES);

    drain();
    @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
